// ===== hw/rtl/first_fit_pool_allocator_core_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check prop on every rising clock edge outside reset.
`define FFPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that post holds in the cycle after pre.
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FFPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== hw/rtl/ffpa_pkg.sv =====
`default_nettype none

package ffpa_pkg;

  localparam int unsigned REQ_W    = 11;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NULL_FREE = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] block_offset;
  } ffpa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    granted_offset;
  } ffpa_rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_EV,
    ST_A_SH_RD,
    ST_A_SH_WR,
    ST_A_WR1,
    ST_A_WR0,
    ST_F_RD,
    ST_F_EV
  } ffpa_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_pool_allocator_core.sv =====
`default_nettype none
`include "first_fit_pool_allocator_core_defines.svh"

// First-fit pool allocator. Pulse start while busy is low to hand over one item
// (allocate or free); busy then stays high until the item is done, but a
// zero-size allocate or a null free is answered from idle with busy staying low.
// The result shows on rsp_o for exactly one cycle with result_valid_o high. The
// receiver cannot stall, so sample rsp_o whenever result_valid_o is high.
// Block headers (payload size and free flag) live in a memory with one write
// port and one registered read port, and every step is one header read or
// write through one shared add/compare unit, so timing follows the block
// count n: an allocate walks headers up to the block k that it hits and, when
// it splits, first moves the entries after k up one; a free walks and
// compacts the whole table. Right after reset, ST_INIT writes the initial
// free block before start is taken.
module first_fit_pool_allocator_core #(
  parameter int unsigned POOL_BYTES   = 1024,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned SPLIT_SLACK  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ffpa_pkg::ffpa_req_t req_i,
  output logic                   result_valid_o,
  output ffpa_pkg::ffpa_rsp_t    rsp_o
);
  import ffpa_pkg::*;

  // Header table sizing: worst case is every block one byte of payload.
  localparam int unsigned MAX_BLOCKS = POOL_BYTES / (HEADER_BYTES + 1) + 1;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SIZE_W     = $clog2(POOL_BYTES + 1);
  localparam int unsigned RND_W      = REQ_W + 1;
  localparam int unsigned CMP_W      = (SIZE_W > RND_W) ? SIZE_W : RND_W;
  localparam int unsigned SUM_A      = $clog2(POOL_BYTES + HEADER_BYTES + 1);
  localparam int unsigned SUM_W      = (SUM_A > OFF_W) ? SUM_A : OFF_W;

  localparam logic [CMP_W-1:0]  SPLIT_LIM = CMP_W'(HEADER_BYTES + SPLIT_SLACK);
  localparam logic [SIZE_W-1:0] HDR_SZ    = SIZE_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0]  HDR_SUM   = SUM_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SZ   = SIZE_W'(POOL_BYTES - HEADER_BYTES);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free_flag;
  } blk_hdr_t;

  ffpa_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;        // read pointer / shift pointer
  logic [CNT_W-1:0]  wr_idx_q, wr_idx_d;  // compaction write pointer / hit index
  logic [SUM_W-1:0]  start_q, start_d;    // byte start of the block being read
  logic [RND_W-1:0]  req_q, req_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [SIZE_W-1:0] rest_q, rest_d;
  blk_hdr_t          acc_q, acc_d;        // merge accumulator
  logic              found_q, found_d;
  ffpa_rsp_t         rsp_q, rsp_d;
  logic              done_q, done_d;

  blk_hdr_t          mem [MAX_BLOCKS];
  blk_hdr_t          rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  blk_hdr_t          mem_wdata;

  // Shared datapath terms.
  logic [RND_W-1:0]  rnd_req;
  logic [CMP_W-1:0]  size_ext, req_ext, rest_full;
  logic              fits, split;
  logic [SUM_W-1:0]  off_here, start_next;
  logic [CNT_W-1:0]  idx_inc, wr_inc;
  logic              match, eff_free;

  assign rnd_req    = (RND_W'(req_i.request_bytes) + RND_W'(7)) & ~RND_W'(7);
  assign size_ext   = CMP_W'(rd_q.size);
  assign req_ext    = CMP_W'(req_q);
  assign rest_full  = size_ext - req_ext;
  assign fits       = rd_q.free_flag && (size_ext >= req_ext);
  assign split      = (rest_full > SPLIT_LIM) && (count_q < CNT_MAX);
  assign off_here   = start_q + HDR_SUM;
  assign start_next = off_here + SUM_W'(rd_q.size);
  assign idx_inc    = idx_q + CNT_ONE;
  assign wr_inc     = wr_idx_q + CNT_ONE;
  assign match      = !found_q && (off_here[OFF_W-1:0] == off_q);
  assign eff_free   = rd_q.free_flag | match;

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = done_q;
  assign rsp_o          = rsp_q;

  // Header memory: one write port, one registered read port at idx.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      count_q <= CNT_ONE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    wr_idx_q <= wr_idx_d;
    start_q  <= start_d;
    req_q    <= req_d;
    off_q    <= off_d;
    rest_q   <= rest_d;
    acc_q    <= acc_d;
    found_q  <= found_d;
    rsp_q    <= rsp_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    wr_idx_d  = wr_idx_q;
    start_d   = start_q;
    req_d     = req_q;
    off_d     = off_q;
    rest_d    = rest_q;
    acc_d     = acc_q;
    found_d   = found_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q[IDX_W-1:0];
    mem_wdata = rd_q;

    case (state_q)
      // Write the single free block that spans the pool.
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{size: INIT_SZ, free_flag: 1'b1};
        count_d   = CNT_ONE;
        state_d   = ST_IDLE;
      end

      ST_IDLE: begin
        idx_d    = '0;
        start_d  = '0;
        wr_idx_d = '0;
        found_d  = 1'b0;
        if (start) begin
          if (req_i.opcode == OP_ALLOC) begin
            if (req_i.request_bytes == '0) begin
              rsp_d  = '{status: STATUS_ZERO_SIZE, granted_offset: '0};
              done_d = 1'b1;
            end else begin
              req_d   = rnd_req;
              state_d = ST_A_RD;
            end
          end else begin
            if (req_i.block_offset == '0) begin
              rsp_d  = '{status: STATUS_NULL_FREE, granted_offset: '0};
              done_d = 1'b1;
            end else begin
              off_d   = req_i.block_offset;
              state_d = ST_F_RD;
            end
          end
        end
      end

      // Allocate: walk headers until the first free block that fits.
      ST_A_RD: begin
        if (idx_q < count_q) begin
          state_d = ST_A_EV;
        end else begin
          rsp_d   = '{status: STATUS_NO_SPACE, granted_offset: '0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_A_EV: begin
        if (fits) begin
          rsp_d    = '{status: STATUS_OK, granted_offset: off_here[OFF_W-1:0]};
          wr_idx_d = idx_q;
          if (split) begin
            rest_d = rest_full[SIZE_W-1:0];
            if (count_q > idx_inc) begin
              idx_d   = count_q - CNT_ONE;
              state_d = ST_A_SH_RD;
            end else begin
              state_d = ST_A_WR1;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = '{size: rd_q.size, free_flag: 1'b0};
            done_d    = 1'b1;
            state_d   = ST_IDLE;
          end
        end else begin
          start_d = start_next;
          idx_d   = idx_inc;
          state_d = ST_A_RD;
        end
      end

      // Open a slot after the hit: move entries up one, top first.
      ST_A_SH_RD: begin
        state_d = ST_A_SH_WR;
      end

      ST_A_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc[IDX_W-1:0];
        if (idx_q == wr_inc) begin
          state_d = ST_A_WR1;
        end else begin
          idx_d   = idx_q - CNT_ONE;
          state_d = ST_A_SH_RD;
        end
      end

      ST_A_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = wr_inc[IDX_W-1:0];
        mem_wdata = '{size: rest_q - HDR_SZ, free_flag: 1'b1};
        count_d   = count_q + CNT_ONE;
        state_d   = ST_A_WR0;
      end

      ST_A_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx_q[IDX_W-1:0];
        mem_wdata = '{size: req_ext[SIZE_W-1:0], free_flag: 1'b0};
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end

      // Free: stream all headers, mark the match, merge free runs in place.
      ST_F_RD: begin
        if (idx_q < count_q) begin
          state_d = ST_F_EV;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_q[IDX_W-1:0];
          mem_wdata = acc_q;
          count_d   = wr_inc;
          rsp_d     = '{status: found_q ? STATUS_OK : STATUS_NULL_FREE,
                        granted_offset: '0};
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      ST_F_EV: begin
        found_d = found_q | match;
        start_d = start_next;
        idx_d   = idx_inc;
        state_d = ST_F_RD;
        if (idx_q == '0) begin
          acc_d = '{size: rd_q.size, free_flag: eff_free};
        end else if (acc_q.free_flag && eff_free) begin
          acc_d.size = acc_q.size + HDR_SZ + rd_q.size;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_q[IDX_W-1:0];
          mem_wdata = acc_q;
          wr_idx_d  = wr_inc;
          acc_d     = '{size: rd_q.size, free_flag: eff_free};
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Block count stays within the header table once the pool is set up.
  `FFPA_ASSERT(a_count_range, clk_i, rst_ni, (state_q != ST_INIT) |-> ((count_q != '0) && (count_q <= CNT_MAX)), "block count out of range")
  // Compaction never writes ahead of the entry being read.
  `FFPA_ASSERT(a_compact_order, clk_i, rst_ni, (state_q == ST_F_EV) |-> (wr_idx_q <= idx_q), "merge write passed read pointer")
  // Every failed or ignored request reports offset zero.
  `FFPA_ASSERT(a_fail_offset, clk_i, rst_ni, (result_valid_o && (rsp_o.status != STATUS_OK)) |-> (rsp_o.granted_offset == '0), "failed request with nonzero offset")
  // A split adds exactly one block.
  `FFPA_ASSERT_NEXT(a_split_count, clk_i, rst_ni, state_q == ST_A_WR1, count_q == ($past(count_q) + CNT_ONE), "split did not add one block")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ffpa_pkg::*;

  // Pool geometry, kept equal to the parameters handed to the instance below.
  localparam int unsigned POOL     = 1024;
  localparam int unsigned HDR      = 24;
  localparam int unsigned SLACK    = 16;
  localparam int unsigned MAX_BLKS = POOL / (HDR + 1) + 1;

  // Give up after this many cycles in which neither an item nor a result moves.
  // A free over a full chain of up to 41 blocks and the longest gap the sender
  // draws both fit well inside this limit, so it leaves a wide margin.
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 630;

  // One queued item for the driver: the request and the cycles to wait first.
  typedef struct packed {
    logic [2:0] gap;
    ffpa_req_t  req;
  } pend_item_t;

  logic      clk_i          = 1'b0;
  logic      rst_ni         = 1'b0;
  logic      start          = 1'b0;
  ffpa_req_t req_i          = '0;
  logic      busy;
  logic      result_valid_o;
  ffpa_rsp_t rsp_o;

  first_fit_pool_allocator_core #(
    .POOL_BYTES  (POOL),
    .HEADER_BYTES(HDR),
    .SPLIT_SLACK (SLACK)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block chain: one entry per block in address order.
  // ---------------------------------------------------------------------------
  int unsigned       blk_size [MAX_BLKS];
  bit                blk_free [MAX_BLKS];
  int unsigned       blk_cnt;
  int unsigned       blk_peak;

  pend_item_t        pend_q[$];      // items waiting for the driver
  ffpa_rsp_t         grant_q[$];     // predicted results, oldest first
  logic [OFF_W-1:0]  live_q[$];      // payload offsets currently handed out

  int unsigned n_grant, n_no_space, n_zero, n_freed, n_ignored;
  int unsigned n_accepted, n_mismatch, n_unexpected;
  int unsigned idle_cycles;

  function automatic void reset_pool();
    int unsigned k;
    for (k = 0; k < MAX_BLKS; k++) begin
      blk_size[k] = 0;
      blk_free[k] = 1'b0;
    end
    blk_size[0] = POOL - HDR;
    blk_free[0] = 1'b1;
    blk_cnt     = 1;
  endfunction

  // Fold every pair of neighboring free blocks into one, left to right.
  function automatic void coalesce_free_runs();
    int unsigned i;
    int unsigned j;
    i = 0;
    while (i + 1 < blk_cnt) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_size[i] = blk_size[i] + HDR + blk_size[i+1];
        for (j = i + 1; j + 1 < blk_cnt; j++) begin
          blk_size[j] = blk_size[j+1];
          blk_free[j] = blk_free[j+1];
        end
        blk_cnt--;
      end else begin
        i++;
      end
    end
  endfunction

  // Apply one accepted item to the shadow chain and return the result it causes.
  function automatic ffpa_rsp_t allocate_or_free(ffpa_req_t r);
    ffpa_rsp_t   rsp;
    int unsigned want;
    int unsigned base;
    int unsigned rest;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    bit          hit;
    rsp  = '0;
    hit  = 1'b0;
    base = 0;
    if (r.opcode == OP_ALLOC) begin
      if (r.request_bytes == '0) begin
        rsp.status = STATUS_ZERO_SIZE;
        n_zero++;
      end else begin
        want = 32'(r.request_bytes);
        want = (want + 7) & ~32'd7;
        for (i = 0; i < blk_cnt; i++) begin
          if (!hit) begin
            if (blk_free[i] && blk_size[i] >= want) begin
              hit  = 1'b1;
              rest = blk_size[i] - want;
              // Split only when the remainder exceeds a header plus slack and the table has room.
              if (rest > HDR + SLACK && blk_cnt < MAX_BLKS) begin
                for (j = blk_cnt; j > i + 1; j--) begin
                  blk_size[j] = blk_size[j-1];
                  blk_free[j] = blk_free[j-1];
                end
                blk_size[i+1] = rest - HDR;
                blk_free[i+1] = 1'b1;
                blk_size[i]   = want;
                blk_cnt++;
              end
              blk_free[i]        = 1'b0;
              rsp.status         = STATUS_OK;
              rsp.granted_offset = OFF_W'(base + HDR);
            end else begin
              base = base + HDR + blk_size[i];
            end
          end
        end
        if (hit) begin
          live_q.push_back(rsp.granted_offset);
          n_grant++;
        end else begin
          rsp.status = STATUS_NO_SPACE;
          n_no_space++;
        end
      end
    end else begin
      if (r.block_offset != '0) begin
        for (i = 0; i < blk_cnt; i++) begin
          if (!hit) begin
            if (OFF_W'(base + HDR) == r.block_offset) begin
              hit         = 1'b1;
              blk_free[i] = 1'b1;
            end else begin
              base = base + HDR + blk_size[i];
            end
          end
        end
      end
      if (hit) begin
        // A double free lands here as well; the merge pass runs either way.
        coalesce_free_runs();
        rsp.status = STATUS_OK;
        n_freed++;
        hit = 1'b0;
        for (k = 0; k < live_q.size(); k++) begin
          if (!hit && live_q[k] == r.block_offset) begin
            live_q.delete(k);
            hit = 1'b1;
          end
        end
      end else begin
        // Null and stray frees are both ignored.
        rsp.status = STATUS_NULL_FREE;
        n_ignored++;
      end
    end
    if (blk_cnt > blk_peak) blk_peak = blk_cnt;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold start and the item until the block takes it, then wait the
  // gap drawn for the next item. A zero gap keeps start high across items.
  // ---------------------------------------------------------------------------
  int unsigned hold_cnt;
  pend_item_t  next_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      req_i    <= '0;
      hold_cnt <= 0;
      reset_pool();
      blk_peak <= 1;
    end else if (start && !busy) begin
      // Item taken at this edge: predict its result now.
      grant_q.push_back(allocate_or_free(req_i));
      n_accepted++;
      if (pend_q.size() > 0 && pend_q[0].gap == 0) begin
        next_item = pend_q.pop_front();
        req_i    <= next_item.req;
      end else if (pend_q.size() > 0) begin
        start    <= 1'b0;
        hold_cnt <= 32'(pend_q[0].gap) - 1;
      end else begin
        start    <= 1'b0;
        hold_cnt <= 0;
      end
    end else if (!start) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (pend_q.size() > 0) begin
        next_item = pend_q.pop_front();
        req_i    <= next_item.req;
        start    <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, ffpa_rsp_t want, ffpa_rsp_t got);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("[%0t] %s: expected status %0d offset %0d, got status %0d offset %0d",
               $realtime, what, want.status, want.granted_offset,
               got.status, got.granted_offset);
    end
  endtask

  always @(posedge clk_i) begin : rsp_monitor
    ffpa_rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (grant_q.size() == 0) begin
        n_unexpected++;
        report_mismatch("result with nothing outstanding", '0, rsp_o);
      end else begin
        want = grant_q.pop_front();
        if (rsp_o.status !== want.status) begin
          report_mismatch("status differs", want, rsp_o);
        end else if (rsp_o.granted_offset !== want.granted_offset) begin
          report_mismatch("granted offset differs", want, rsp_o);
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout: no item or result moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  bit no_idle;   // when set, queue items back to back

  task automatic queue_item(logic op, int unsigned nbytes, int unsigned off);
    pend_item_t it;
    it.req.opcode        = op;
    it.req.request_bytes = REQ_W'(nbytes);
    it.req.block_offset  = OFF_W'(off);
    it.gap               = no_idle ? 3'd0 : 3'($urandom_range(0, 6));
    // Keep the queue short so frees pick from an up-to-date set of live blocks.
    while (pend_q.size() > 1) @(negedge clk_i);
    pend_q.push_back(it);
  endtask

  // Mostly small sizes so the chain grows long; now and then a large one.
  function automatic int unsigned draw_size();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 96);
    return $urandom_range(97, POOL);
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned r;
    int unsigned pick;
    no_idle   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: edges of each field, every status, split boundary.
    queue_item(OP_ALLOC, 0, 0);        // zero-size allocate
    queue_item(OP_FREE, 0, 0);         // null free
    queue_item(OP_FREE, 0, 5);         // stray free
    queue_item(OP_ALLOC, 1, 0);        // smallest grant, rounds up to 8
    queue_item(OP_ALLOC, POOL, 0);     // larger than any block
    queue_item(OP_ALLOC, 9, 0);        // rounds up to 16, splits the tail
    queue_item(OP_FREE, 0, 1023);      // stray free at the top offset
    queue_item(OP_FREE, 0, 24);
    queue_item(OP_FREE, 0, 24);        // double free
    queue_item(OP_FREE, 0, 56);        // merges the whole pool back
    queue_item(OP_ALLOC, 1000, 0);     // exact fit of the whole pool
    queue_item(OP_ALLOC, 8, 0);        // pool exhausted
    queue_item(OP_FREE, 0, 24);
    queue_item(OP_ALLOC, 960, 0);      // remainder equals header plus slack: no split
    queue_item(OP_FREE, 0, 24);
    queue_item(OP_ALLOC, 952, 0);      // remainder just above the split threshold
    queue_item(OP_ALLOC, 17, 0);       // fills the split-off block exactly
    queue_item(OP_ALLOC, 7, 0);        // nothing left
    queue_item(OP_FREE, 0, 1000);
    queue_item(OP_FREE, 0, 24);
    queue_item(OP_ALLOC, 1023, 1023);  // unused offset field all ones
    queue_item(OP_FREE, POOL, 10'h2aa); // unused size field set, stray offset

    // Random part: mostly allocate/free of live blocks, with some noise.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
      // Now and then release every live block, in random order.
      if (n % 150 == 149) begin
        while (live_q.size() > 0 || pend_q.size() > 0 || start) begin
          if (live_q.size() > 0) begin
            pick = $urandom_range(0, live_q.size() - 1);
            queue_item(OP_FREE, $urandom_range(0, POOL), live_q[pick]);
            while (pend_q.size() > 0 || start) @(negedge clk_i);
          end else begin
            @(negedge clk_i);
          end
        end
      end
      r = $urandom_range(0, 99);
      if (r < 40 || (r < 75 && live_q.size() == 0)) begin
        queue_item(OP_ALLOC, draw_size(), $urandom_range(0, 1023));
      end else if (r < 75) begin
        pick = $urandom_range(0, live_q.size() - 1);
        queue_item(OP_FREE, $urandom_range(0, POOL), live_q[pick]);
      end else if (r < 82) begin
        queue_item(OP_FREE, $urandom_range(0, POOL), $urandom_range(0, 1023));
      end else if (r < 86) begin
        queue_item(OP_FREE, $urandom_range(0, POOL), 0);
      end else if (r < 91) begin
        queue_item(OP_ALLOC, 0, $urandom_range(0, 1023));
      end else begin
        queue_item(OP_ALLOC, $urandom_range(POOL / 2, POOL), $urandom_range(0, 1023));
      end
    end

    // Drain: wait for the last item to be taken and every result to arrive.
    while (pend_q.size() > 0 || start || grant_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d items: %0d grants, %0d out of space, %0d zero-size, %0d frees, %0d ignored",
             n_accepted, n_grant, n_no_space, n_zero, n_freed, n_ignored);
    $display("Longest block chain reached %0d blocks; %0d mismatches, %0d stray results, %0d missing",
             blk_peak, n_mismatch, n_unexpected, grant_q.size());
    if (n_mismatch == 0 && grant_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
